// File: sv/qte_pkg.sv
// Shared constants, types and the arctangent step table for the quaternion to Euler converter.
package qte_pkg;

  // Input quaternion component width, Q2.14.
  localparam int QW = 16;
  // Width of the Q.28 product sums (sine and cosine terms).
  localparam int PW = 35;
  // Width of the pitch sine term once it is known to be below 1.0 in magnitude.
  localparam int SPW = 29;
  // Width of the squared cosine term fed to the square root.
  localparam int C2W = 57;
  // Working width inside the square root pipeline.
  localparam int RW = 58;
  // One square root stage per result bit.
  localparam int SQ_STAGES = 29;
  // CORDIC datapath widths.
  localparam int MW = 36;
  localparam int CW = 62;
  localparam int ZW = 32;
  localparam int SHW = 6;
  localparam int NSTEPS = 28;
  // The larger operand magnitude is shifted up until its top bit lands here.
  localparam int NORM_MSB = 57;
  // Output angle widths.
  localparam int AW = 16;
  localparam int LW = 15;
  localparam int RNDW = 17;

  localparam logic signed [PW-1:0] ONE_Q28 = 35'sd268435456;
  localparam logic [RW-1:0] ONE_Q56 = 58'd1 << 56;
  localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
  localparam logic [LW-1:0] LIM_PI = 15'd25736;
  localparam logic [LW-1:0] LIM_HALF_PI = 15'd12868;
  localparam logic signed [LW-1:0] HALF_PI_Q13 = 15'sd12868;

  // Operands that ride along the square root pipeline.
  typedef struct packed {
    logic signed [PW-1:0]  sr;
    logic signed [PW-1:0]  cr;
    logic signed [PW-1:0]  sy;
    logic signed [PW-1:0]  cy;
    logic signed [SPW-1:0] sp;
    logic                  sat;
    logic                  sneg;
  } qte_side_t;

  // Pitch status that rides along the pitch CORDIC.
  typedef struct packed {
    logic sat;
    logic sneg;
  } qte_tag_t;

  // Angle of CORDIC step i in units of 2^-28 rad.
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] t;
    unique case (i)
      0: t = 32'sd210828714;
      1: t = 32'sd124459457;
      2: t = 32'sd65760959;
      3: t = 32'sd33381290;
      4: t = 32'sd16755422;
      5: t = 32'sd8385879;
      6: t = 32'sd4193963;
      7: t = 32'sd2097109;
      8: t = 32'sd1048571;
      9: t = 32'sd524287;
      default: t = 32'sd1 <<< (NSTEPS - i);
    endcase
    return t;
  endfunction

endpackage

// File: sv/quaternion_to_euler_angles.sv
// Top level: converts a stream of Q2.14 quaternions to ZYX Euler angles in Q3.13 radians.
//
// The input channel takes one quaternion word per handshake on in_tdata, w in the
// lowest 16 bits, then x, y and z. The output channel gives one word per input word,
// in order: roll, pitch and yaw on out_tdata, and the pitch clamp flag on out_tuser.
// A pitch sine of magnitude 1.0 or more gives pitch of plus or minus pi/2 and sets
// the flag.
// Throughput is one word per cycle while the output is not stalled. The pipeline
// holds 4 product stages, 29 square root stages (one root bit each for the
// pitch cosine), 32 CORDIC stages (fold, leading one, shift, 28 rotations, round)
// and the output register. The square root sets the pipeline depth; the three
// CORDIC units run side by side.
// The whole pipeline advances together. When the output register holds a word that
// is not taken, every stage holds and in_tready is low, so nothing is lost or
// repeated. A synchronous reset (rst_n low) clears all valid bits, the output
// valid among them, but not the output data; words in flight are dropped.
module quaternion_to_euler_angles (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], zero
  output logic [0:0]  out_tuser   // pitch_saturated[0]
);
  import qte_pkg::*;

  logic      en;
  logic      prod_vld, sq_vld, cor_vld;
  qte_side_t prod_side, sq_side;
  logic [C2W-1:0] prod_c2;
  logic [SPW-1:0] sq_root;
  logic signed [AW-1:0] roll_ang, pitch_ang, yaw_ang;
  qte_tag_t  pitch_tag, in_tag, zero_tag;
  logic      out_tvalid_r;
  logic [47:0] out_tdata_r, out_tdata_nxt;
  logic [0:0]  out_tuser_r;
  logic signed [LW-1:0] pitch_nxt;

  // Global advance: hold everything while the output word waits.
  assign en        = ~out_tvalid_r | out_tready;
  assign in_tready = en;

  qte_prod u_prod (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .quat_w (signed'(in_tdata[15:0])),
    .quat_x (signed'(in_tdata[31:16])),
    .quat_y (signed'(in_tdata[47:32])),
    .quat_z (signed'(in_tdata[63:48])),
    .vld_o  (prod_vld),
    .side_o (prod_side),
    .c2_o   (prod_c2)
  );

  qte_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (prod_vld),
    .c2_i   (prod_c2),
    .side_i (prod_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  assign in_tag.sat  = sq_side.sat;
  assign in_tag.sneg = sq_side.sneg;
  assign zero_tag    = '0;

  qte_cordic u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sq_vld),
    .y_i     (sq_side.sr),
    .x_i     (sq_side.cr),
    .lim_i   (LIM_PI),
    .tag_i   (zero_tag),
    .vld_o   (),
    .angle_o (roll_ang),
    .tag_o   ()
  );

  qte_cordic u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sq_vld),
    .y_i     (PW'(sq_side.sp)),
    .x_i     (PW'(signed'({1'b0, sq_root}))),
    .lim_i   (LIM_HALF_PI),
    .tag_i   (in_tag),
    .vld_o   (cor_vld),
    .angle_o (pitch_ang),
    .tag_o   (pitch_tag)
  );

  qte_cordic u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sq_vld),
    .y_i     (sq_side.sy),
    .x_i     (sq_side.cy),
    .lim_i   (LIM_PI),
    .tag_i   (zero_tag),
    .vld_o   (),
    .angle_o (yaw_ang),
    .tag_o   ()
  );

  // Clamped pitch replaces the CORDIC result when the sine reached 1.0.
  always_comb begin
    if (pitch_tag.sat) begin
      pitch_nxt = pitch_tag.sneg ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      pitch_nxt = pitch_ang[LW-1:0];
    end
    out_tdata_nxt = {1'b0, yaw_ang, pitch_nxt, roll_ang};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= cor_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= pitch_tag.sat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  logic signed [AW-1:0] chk_roll, chk_yaw;
  logic signed [LW-1:0] chk_pitch;
  assign chk_roll  = out_tdata[15:0];
  assign chk_pitch = out_tdata[30:16];
  assign chk_yaw   = out_tdata[46:31];

  // A clamped pitch is exactly plus or minus pi/2.
  a_sat_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (chk_pitch == HALF_PI_Q13 || chk_pitch == -HALF_PI_Q13))
    else $error("clamped pitch is not pi/2");

  // Roll and yaw stay within plus or minus pi.
  a_roll_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_roll >= -25736 && chk_roll <= 25736 &&
                    chk_yaw >= -25736 && chk_yaw <= 25736))
    else $error("roll or yaw out of range");

  // Pitch stays within plus or minus pi/2.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_pitch >= -HALF_PI_Q13 && chk_pitch <= HALF_PI_Q13))
    else $error("pitch out of range");

  // A stalled output word freezes the pipeline entry as well.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted during output stall");
`endif

endmodule

// File: sv/qte_prod.sv
// Product and sum stages: forms the sine and cosine terms and the squared pitch cosine.
module qte_prod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic signed [15:0]         quat_w,
  input  logic signed [15:0]         quat_x,
  input  logic signed [15:0]         quat_y,
  input  logic signed [15:0]         quat_z,
  output logic                       vld_o,
  output qte_pkg::qte_side_t         side_o,
  output logic [qte_pkg::C2W-1:0]    c2_o
);
  import qte_pkg::*;

  logic signed [2*QW-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r, p_wy_r, p_zx_r;
  logic [3:0] vld_r;
  qte_side_t s2_side_r, s3_side_r, s4_side_r;
  qte_side_t s2_side_nxt;
  logic signed [PW-1:0] sp_nxt;
  logic signed [2*SPW-1:0] s3_sq_r, s3_sq_nxt;
  logic [C2W-1:0] c2_r;

  // Valid bits follow the data through all four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  // Sums of products, doubled, in Q.28.
  always_comb begin
    sp_nxt           = (PW'(p_wy_r) - PW'(p_zx_r)) <<< 1;
    s2_side_nxt.sr   = (PW'(p_wx_r) + PW'(p_yz_r)) <<< 1;
    s2_side_nxt.cr   = ONE_Q28 - ((PW'(p_xx_r) + PW'(p_yy_r)) <<< 1);
    s2_side_nxt.sy   = (PW'(p_wz_r) + PW'(p_xy_r)) <<< 1;
    s2_side_nxt.cy   = ONE_Q28 - ((PW'(p_yy_r) + PW'(p_zz_r)) <<< 1);
    s2_side_nxt.sp   = sp_nxt[SPW-1:0];
    s2_side_nxt.sat  = (sp_nxt >= ONE_Q28) || (sp_nxt <= -ONE_Q28);
    s2_side_nxt.sneg = sp_nxt < 0;
  end

  // Square of the pitch sine; only meaningful when the sine is below 1.0.
  assign s3_sq_nxt = s2_side_r.sp * s2_side_r.sp;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r    <= quat_w * quat_x;
      p_yz_r    <= quat_y * quat_z;
      p_xx_r    <= quat_x * quat_x;
      p_yy_r    <= quat_y * quat_y;
      p_wz_r    <= quat_w * quat_z;
      p_xy_r    <= quat_x * quat_y;
      p_zz_r    <= quat_z * quat_z;
      p_wy_r    <= quat_w * quat_y;
      p_zx_r    <= quat_z * quat_x;
      s2_side_r <= s2_side_nxt;
      s3_side_r <= s2_side_r;
      s3_sq_r   <= s3_sq_nxt;
      s4_side_r <= s3_side_r;
      c2_r      <= C2W'(ONE_Q56 - unsigned'(s3_sq_r));
    end
  end

  assign vld_o  = vld_r[3];
  assign side_o = s4_side_r;
  assign c2_o   = c2_r;

endmodule

// File: sv/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage, with side operands carried along.
module qte_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [qte_pkg::C2W-1:0]    c2_i,
  input  qte_pkg::qte_side_t         side_i,
  output logic                       vld_o,
  output logic [qte_pkg::SPW-1:0]    root_o,
  output qte_pkg::qte_side_t         side_o
);
  import qte_pkg::*;

  logic [RW-1:0] v_r     [SQ_STAGES];
  logic [RW-1:0] res_r   [SQ_STAGES];
  logic [RW-1:0] v_in    [SQ_STAGES];
  logic [RW-1:0] res_in  [SQ_STAGES];
  logic [RW-1:0] v_nxt   [SQ_STAGES];
  logic [RW-1:0] res_nxt [SQ_STAGES];
  logic [RW-1:0] trial   [SQ_STAGES];
  logic [RW-1:0] bitv    [SQ_STAGES];
  qte_side_t side_r [SQ_STAGES];
  logic [SQ_STAGES-1:0] vld_r;

  // Each stage tries one root bit: subtract when the remainder allows it.
  always_comb begin
    v_in[0]   = RW'(c2_i);
    res_in[0] = '0;
    for (int k = 1; k < SQ_STAGES; k++) begin
      v_in[k]   = v_r[k-1];
      res_in[k] = res_r[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      bitv[k]  = RW'(1) << (2 * (SQ_STAGES - 1 - k));
      trial[k] = res_in[k] + bitv[k];
      if (v_in[k] >= trial[k]) begin
        v_nxt[k]   = v_in[k] - trial[k];
        res_nxt[k] = (res_in[k] >> 1) + bitv[k];
      end else begin
        v_nxt[k]   = v_in[k];
        res_nxt[k] = res_in[k] >> 1;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STAGES-2:0], vld_i};
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int k = 1; k < SQ_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k < SQ_STAGES; k++) begin
        v_r[k]   <= v_nxt[k];
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign vld_o  = vld_r[SQ_STAGES-1];
  assign root_o = res_r[SQ_STAGES-1][SPW-1:0];
  assign side_o = side_r[SQ_STAGES-1];

endmodule

// File: sv/qte_cordic.sv
// Pipelined vectoring CORDIC atan2 with operand normalization and Q3.13 rounding.
module qte_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [qte_pkg::PW-1:0] y_i,
  input  logic signed [qte_pkg::PW-1:0] x_i,
  input  logic [qte_pkg::LW-1:0]        lim_i,
  input  qte_pkg::qte_tag_t             tag_i,
  output logic                          vld_o,
  output logic signed [qte_pkg::AW-1:0] angle_o,
  output qte_pkg::qte_tag_t             tag_o
);
  import qte_pkg::*;

  localparam int NST = NSTEPS + 4;

  logic [NST-1:0] vld_r;
  qte_tag_t tag_r [NST];
  logic zero_r [NST];

  // Fold stage.
  logic signed [MW-1:0] a_x_r, a_y_r, a_x_nxt, a_y_nxt, a_yabs;
  logic signed [ZW-1:0] a_z_r, a_z_nxt;
  logic [MW-1:0] a_m_r;
  // Leading one stage.
  logic signed [MW-1:0] b_x_r, b_y_r;
  logic signed [ZW-1:0] b_z_r;
  logic [SHW-1:0] b_s_r, b_s_nxt, b_p;
  // Rotation stages; entry k holds the input of step k.
  logic signed [CW-1:0] it_x_r [NSTEPS+1];
  logic signed [CW-1:0] it_y_r [NSTEPS+1];
  logic signed [ZW-1:0] it_z_r [NSTEPS+1];
  logic signed [CW-1:0] x_nxt [NSTEPS];
  logic signed [CW-1:0] y_nxt [NSTEPS];
  logic signed [ZW-1:0] z_nxt [NSTEPS];
  // Rounding stage.
  logic signed [AW-1:0] angle_r, angle_nxt;
  logic                 r_neg;
  logic [ZW-1:0]        r_mag;
  logic [RNDW-1:0]      r_q;

  // Move a negative x to the right half plane and start the angle at plus or minus pi.
  always_comb begin
    if (x_i < 0) begin
      a_x_nxt = -MW'(x_i);
      a_y_nxt = -MW'(y_i);
      a_z_nxt = (y_i >= 0) ? PI_Q28 : -PI_Q28;
    end else begin
      a_x_nxt = MW'(x_i);
      a_y_nxt = MW'(y_i);
      a_z_nxt = '0;
    end
    a_yabs = (a_y_nxt < 0) ? -a_y_nxt : a_y_nxt;
  end

  // Find the top set bit of x or |y| and the shift that brings it to the normalizing position.
  always_comb begin
    b_p = '0;
    for (int b = 0; b < MW; b++) begin
      if (a_m_r[b]) begin
        b_p = SHW'(b);
      end
    end
    b_s_nxt = (a_m_r == '0) ? '0 : SHW'(NORM_MSB) - b_p;
  end

  // One micro-rotation per stage, driving y toward zero.
  always_comb begin
    for (int k = 0; k < NSTEPS; k++) begin
      if (it_y_r[k] > 0) begin
        x_nxt[k] = it_x_r[k] + (it_y_r[k] >>> k);
        y_nxt[k] = it_y_r[k] - (it_x_r[k] >>> k);
        z_nxt[k] = it_z_r[k] + atan_step(k);
      end else begin
        x_nxt[k] = it_x_r[k] - (it_y_r[k] >>> k);
        y_nxt[k] = it_y_r[k] + (it_x_r[k] >>> k);
        z_nxt[k] = it_z_r[k] - atan_step(k);
      end
    end
  end

  // Round to Q3.13 with halves away from zero, then clamp the magnitude.
  always_comb begin
    r_neg = it_z_r[NSTEPS] < 0;
    r_mag = r_neg ? unsigned'(-it_z_r[NSTEPS]) : unsigned'(it_z_r[NSTEPS]);
    r_q   = RNDW'((r_mag + ZW'(16384)) >> 15);
    if (r_q > RNDW'(lim_i)) begin
      r_q = RNDW'(lim_i);
    end
    if (zero_r[NST-2]) begin
      angle_nxt = '0;
    end else if (r_neg) begin
      angle_nxt = -signed'(AW'(r_q));
    end else begin
      angle_nxt = signed'(AW'(r_q));
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], vld_i};
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0]  <= tag_i;
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      for (int k = 1; k < NST; k++) begin
        tag_r[k]  <= tag_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
      a_x_r     <= a_x_nxt;
      a_y_r     <= a_y_nxt;
      a_z_r     <= a_z_nxt;
      a_m_r     <= unsigned'(a_x_nxt) | unsigned'(a_yabs);
      b_x_r     <= a_x_r;
      b_y_r     <= a_y_r;
      b_z_r     <= a_z_r;
      b_s_r     <= b_s_nxt;
      it_x_r[0] <= CW'(b_x_r) <<< b_s_r;
      it_y_r[0] <= CW'(b_y_r) <<< b_s_r;
      it_z_r[0] <= b_z_r;
      for (int k = 0; k < NSTEPS; k++) begin
        it_x_r[k+1] <= x_nxt[k];
        it_y_r[k+1] <= y_nxt[k];
        it_z_r[k+1] <= z_nxt[k];
      end
      angle_r   <= angle_nxt;
    end
  end

  assign vld_o   = vld_r[NST-1];
  assign angle_o = angle_r;
  assign tag_o   = tag_r[NST-1];

endmodule
